FILE: design/crr_pkg.sv
// ----------------------------------------------------------------------------
// Circle rasterizer package
// Shared widths, command codes and the step record passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package crr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 10;
    localparam int OFF_BITS    = RADIUS_BITS + 1;
    localparam int ERR_BITS    = RADIUS_BITS + 3;
    localparam int OUT_BITS    = 14;

    localparam int S_FIELD_BITS = 2 * COORD_BITS + RADIUS_BITS;
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = 3 * OUT_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    localparam int MAX_RESULTS = 8;
    localparam int IDX_BITS    = $clog2(MAX_RESULTS);
    localparam int FILL_LAST   = 3;
    localparam int LINE_LAST   = 7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0]      center_col;
        logic [COORD_BITS-1:0]      center_row;
        logic signed [OFF_BITS-1:0] off_x;
        logic signed [OFF_BITS-1:0] off_y;
        logic                       fill;
        logic                       done;
    } step_t;

endpackage

`default_nettype wire

FILE: design/crr_front.sv
// ----------------------------------------------------------------------------
// Circle rasterizer front end
// Takes commands, keeps the circle state and queues one record per step.
// ----------------------------------------------------------------------------
`default_nettype none

module crr_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [crr_pkg::S_TDATA_BITS-1:0]  s_tdata,
    input  wire logic                              s_tuser,
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_wr_data,
    output logic                                   push_valid,
    output crr_pkg::step_t                         push_data,
    input  wire logic                              push_ready
);

    localparam int W = crr_pkg::ERR_BITS + 1;

    logic [crr_pkg::COORD_BITS-1:0]       col_reg, col_next;
    logic [crr_pkg::COORD_BITS-1:0]       row_reg, row_next;
    logic [crr_pkg::RADIUS_BITS-1:0]      rad_reg, rad_next;
    logic signed [crr_pkg::OFF_BITS-1:0]  offx_reg, offx_next;
    logic signed [crr_pkg::OFF_BITS-1:0]  offy_reg, offy_next;
    logic signed [crr_pkg::ERR_BITS-1:0]  err_reg, err_next;
    logic                                 active_reg, active_next;
    logic                                 fill_reg, fill_next;

    logic                                 s_acc, start, step;
    logic [crr_pkg::COORD_BITS-1:0]       in_col, in_row;
    logic [crr_pkg::RADIUS_BITS-1:0]      in_rad;
    logic signed [W-1:0]                  e_w, x_w, y_w, r_w, two_x, lim;
    logic signed [W-1:0]                  e_n, x_n, y_n;
    logic                                 done;

    assign s_tready = push_ready;
    assign s_acc    = s_tvalid && s_tready;
    assign start    = s_acc && (s_tuser == crr_pkg::CMD_START);
    assign step     = s_acc && (s_tuser == crr_pkg::CMD_STEP) && active_reg;

    assign in_col = s_tdata[crr_pkg::COORD_BITS-1:0];
    assign in_row = s_tdata[2*crr_pkg::COORD_BITS-1:crr_pkg::COORD_BITS];
    assign in_rad = s_tdata[crr_pkg::S_FIELD_BITS-1:2*crr_pkg::COORD_BITS];

    always_comb begin
        e_w   = W'(err_reg);
        x_w   = W'(offx_reg);
        y_w   = W'(offy_reg);
        r_w   = signed'(W'(rad_reg));
        two_x = x_w <<< 1;
        lim   = (r_w - y_w) <<< 1;
        priority if (e_w >= two_x) begin
            e_n = e_w - two_x - W'(1);
            x_n = x_w + W'(1);
            y_n = y_w;
        end else if (e_w < lim) begin
            e_n = e_w + (y_w <<< 1) - W'(1);
            x_n = x_w;
            y_n = y_w - W'(1);
        end else begin
            e_n = e_w + ((y_w - x_w - W'(1)) <<< 1);
            x_n = x_w + W'(1);
            y_n = y_w - W'(1);
        end
        done = (y_n < x_n);
    end

    always_comb begin
        col_next    = col_reg;
        row_next    = row_reg;
        rad_next    = rad_reg;
        offx_next   = offx_reg;
        offy_next   = offy_reg;
        err_next    = err_reg;
        active_next = active_reg;
        fill_next   = cfg_wr_en ? cfg_wr_data : fill_reg;
        if (start) begin
            col_next    = in_col;
            row_next    = in_row;
            rad_next    = in_rad;
            offx_next   = '0;
            offy_next   = signed'(crr_pkg::OFF_BITS'(in_rad));
            err_next    = signed'(crr_pkg::ERR_BITS'(in_rad) - crr_pkg::ERR_BITS'(1));
            active_next = 1'b1;
        end else if (step) begin
            offx_next   = x_n[crr_pkg::OFF_BITS-1:0];
            offy_next   = y_n[crr_pkg::OFF_BITS-1:0];
            err_next    = e_n[crr_pkg::ERR_BITS-1:0];
            active_next = !done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            rad_reg    <= '0;
            offx_reg   <= '0;
            offy_reg   <= '0;
            err_reg    <= '0;
            active_reg <= 1'b0;
            fill_reg   <= 1'b0;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            rad_reg    <= rad_next;
            offx_reg   <= offx_next;
            offy_reg   <= offy_next;
            err_reg    <= err_next;
            active_reg <= active_next;
            fill_reg   <= fill_next;
        end
    end

    assign push_valid           = step;
    assign push_data.center_col = col_reg;
    assign push_data.center_row = row_reg;
    assign push_data.off_x      = offx_reg;
    assign push_data.off_y      = offy_reg;
    assign push_data.fill       = fill_reg;
    assign push_data.done       = done;

    // A completing step leaves the block idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && done) |=> !active_reg)
        else $error("circle still active after its final step");

    // A start always restarts the octant walk at the top of the circle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> (active_reg && offx_reg == '0 && offy_reg >= 0))
        else $error("start did not reset the offsets");

endmodule

`default_nettype wire

FILE: design/crr_fifo.sv
// ----------------------------------------------------------------------------
// Circle rasterizer step queue
// Small register FIFO that decouples the front end from the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module crr_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    input  crr_pkg::step_t      push_data,
    output logic                push_ready,
    output logic                pop_valid,
    output crr_pkg::step_t      pop_data,
    input  wire logic           pop_ready
);

    crr_pkg::step_t                 mem [crr_pkg::QUEUE_DEPTH];
    logic [crr_pkg::QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [crr_pkg::QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [crr_pkg::QCNT_BITS-1:0]  count_reg, count_next;
    logic                           push, pop;

    assign push_ready = (count_reg != crr_pkg::QCNT_BITS'(crr_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == crr_pkg::QPTR_BITS'(crr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + crr_pkg::QPTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == crr_pkg::QPTR_BITS'(crr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + crr_pkg::QPTR_BITS'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + crr_pkg::QCNT_BITS'(1);
        end else if (pop && !push) begin
            count_next = count_reg - crr_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= crr_pkg::QCNT_BITS'(crr_pkg::QUEUE_DEPTH))
        else $error("step queue overfilled");

endmodule

`default_nettype wire

FILE: design/crr_back.sv
// ----------------------------------------------------------------------------
// Circle rasterizer output sequencer
// Expands each step into points or spans, one per cycle as m_tready allows.
// ----------------------------------------------------------------------------
`default_nettype none

module crr_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              pop_valid,
    input  crr_pkg::step_t                         pop_data,
    output logic                                   pop_ready,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [crr_pkg::M_TDATA_BITS-1:0]       m_tdata,
    output logic                                   m_tlast,
    output logic                                   m_tuser
);

    localparam int OB = crr_pkg::OUT_BITS;

    crr_pkg::step_t                  cur_reg, cur_next;
    logic                            cur_valid_reg, cur_valid_next;
    logic [crr_pkg::IDX_BITS-1:0]    idx_reg, idx_next;
    logic                            out_valid_reg, out_valid_next;
    logic signed [OB-1:0]            xs_reg, xs_next;
    logic signed [OB-1:0]            xe_reg, xe_next;
    logic signed [OB-1:0]            row_reg, row_next;
    logic                            last_reg, last_next;
    logic                            done_reg, done_next;

    logic                            load_out, is_last, take;
    logic                            use_y_h, neg_h, neg_v;
    logic signed [OB-1:0]            cx, cy, ox, oy, h, v;

    assign load_out = cur_valid_reg && (!out_valid_reg || m_tready);
    assign is_last  = cur_reg.fill
                    ? (idx_reg == crr_pkg::IDX_BITS'(crr_pkg::FILL_LAST))
                    : (idx_reg == crr_pkg::IDX_BITS'(crr_pkg::LINE_LAST));
    assign pop_ready = !cur_valid_reg || (load_out && is_last);
    assign take      = pop_valid && pop_ready;

    always_comb begin
        cx = signed'(OB'(cur_reg.center_col));
        cy = signed'(OB'(cur_reg.center_row));
        ox = OB'(cur_reg.off_x);
        oy = OB'(cur_reg.off_y);
        if (cur_reg.fill) begin
            use_y_h = (idx_reg == crr_pkg::IDX_BITS'(0)) ||
                      (idx_reg == crr_pkg::IDX_BITS'(crr_pkg::FILL_LAST));
            neg_h   = 1'b0;
            neg_v   = idx_reg[1];
        end else begin
            use_y_h = idx_reg[0];
            neg_h   = idx_reg[1];
            neg_v   = idx_reg[2];
        end
        h = use_y_h ? oy : ox;
        v = use_y_h ? ox : oy;
    end

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        xs_next        = xs_reg;
        xe_next        = xe_reg;
        row_next       = row_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (load_out) begin
            out_valid_next = 1'b1;
            if (cur_reg.fill) begin
                xs_next = cx - h;
                xe_next = cx + h;
            end else begin
                xs_next = neg_h ? (cx - h) : (cx + h);
                xe_next = neg_h ? (cx - h) : (cx + h);
            end
            row_next  = neg_v ? (cy - v) : (cy + v);
            last_next = is_last;
            done_next = cur_reg.done;
            idx_next  = idx_reg + crr_pkg::IDX_BITS'(1);
            if (is_last) begin
                cur_valid_next = 1'b0;
                idx_next       = '0;
            end
        end
        if (take) begin
            cur_next       = pop_data;
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        xs_reg   <= xs_next;
        xe_reg   <= xe_next;
        row_reg  <= row_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = crr_pkg::M_TDATA_BITS'({row_reg, xe_reg, xs_reg});
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        !cur_valid_reg |-> (idx_reg == '0))
        else $error("item index left over with no step in hand");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_valid_reg && cur_reg.fill) |-> !idx_reg[crr_pkg::IDX_BITS-1])
        else $error("span index beyond the fourth span");

endmodule

`default_nettype wire

FILE: design/circle_rasterizer.sv
// ----------------------------------------------------------------------------
// Circle rasterizer
// Integer circle walk giving eight outline points or four spans per step.
//
//   channel  dir  accept               tdata (low bit up)          side bands
//   s_       in   s_tvalid & s_tready  center_x, center_y, radius  tuser = cmd
//   m_       out  m_tvalid & m_tready  x_start, x_end, row         tlast, tuser = done
//   cfg_     in   cfg_wr_en            fill_mode                   -
//
// A step gives one item per cycle while m_tready is high: eight items in outline
// mode, four in fill, via the single output register. Commands are taken every cycle
// while the two-entry step queue has room. Starts and idle steps give no item.
// Reset is synchronous, active low, and leaves the block idle in outline mode.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_rasterizer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // center_x, center_y, radius
    input  wire logic [crr_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // cmd
    input  wire logic                              s_tuser,
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_wr_data,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // x_start, x_end, row
    output logic [crr_pkg::M_TDATA_BITS-1:0]       m_tdata,
    output logic                                   m_tlast,
    // done_res
    output logic                                   m_tuser
);

    logic            push_valid, push_ready, pop_valid, pop_ready;
    crr_pkg::step_t  push_data, pop_data;

    crr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push_valid  (push_valid),
        .push_data   (push_data),
        .push_ready  (push_ready)
    );

    crr_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    crr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

FILE: test/circle_rasterizer_check.sv
// ----------------------------------------------------------------------------
// Circle rasterizer checker
// Watches the command, configuration and result channels, keeps its own copy
// of the circle walk, and compares every result item with the oldest span or
// point still due, field by field.
// ----------------------------------------------------------------------------

module circle_rasterizer_check (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    // center_x, center_y, radius
    input  wire logic [crr_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // cmd
    input  wire logic                              s_tuser,
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_wr_data,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    // x_start, x_end, row
    input  wire logic [crr_pkg::M_TDATA_BITS-1:0]  m_tdata,
    input  wire logic                              m_tlast,
    // done_res
    input  wire logic                              m_tuser,
    output int                                     mismatches,
    output int                                     outstanding
);

    typedef struct {
        logic [crr_pkg::OUT_BITS-1:0] x_start;
        logic [crr_pkg::OUT_BITS-1:0] x_end;
        logic [crr_pkg::OUT_BITS-1:0] row;
        logic                         last;
        logic                         done;
    } span_t;

    span_t                           spans_due[$];
    logic [crr_pkg::COORD_BITS-1:0]  ctr_col;
    logic [crr_pkg::COORD_BITS-1:0]  ctr_row;
    logic [crr_pkg::RADIUS_BITS-1:0] rad;
    int                              walk_x;
    int                              walk_y;
    int                              walk_err;
    logic                            drawing;
    logic                            fill;

    function automatic span_t span(int xs, int xe, int r);
        span_t s;
        s.x_start = xs[crr_pkg::OUT_BITS-1:0];
        s.x_end   = xe[crr_pkg::OUT_BITS-1:0];
        s.row     = r[crr_pkg::OUT_BITS-1:0];
        s.last    = 1'b0;
        s.done    = 1'b0;
        return s;
    endfunction

    task automatic report(string what);
        mismatches++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic rasterize(logic cmd, logic [crr_pkg::S_TDATA_BITS-1:0] d);
        span_t run[crr_pkg::MAX_RESULTS];
        int    cx;
        int    cy;
        int    n;
        logic  finished;
        if (cmd == crr_pkg::CMD_START) begin
            ctr_col  = d[crr_pkg::COORD_BITS-1:0];
            ctr_row  = d[2*crr_pkg::COORD_BITS-1:crr_pkg::COORD_BITS];
            rad      = d[crr_pkg::S_FIELD_BITS-1:2*crr_pkg::COORD_BITS];
            walk_x   = 0;
            walk_y   = int'(rad);
            walk_err = int'(rad) - 1;
            drawing  = 1'b1;
            return;
        end
        if (!drawing) begin
            return;
        end
        cx = int'(ctr_col);
        cy = int'(ctr_row);
        if (fill) begin
            run[0] = span(cx - walk_y, cx + walk_y, cy + walk_x);
            run[1] = span(cx - walk_x, cx + walk_x, cy + walk_y);
            run[2] = span(cx - walk_x, cx + walk_x, cy - walk_y);
            run[3] = span(cx - walk_y, cx + walk_y, cy - walk_x);
            n = crr_pkg::FILL_LAST + 1;
        end else begin
            run[0] = span(cx + walk_x, cx + walk_x, cy + walk_y);
            run[1] = span(cx + walk_y, cx + walk_y, cy + walk_x);
            run[2] = span(cx - walk_x, cx - walk_x, cy + walk_y);
            run[3] = span(cx - walk_y, cx - walk_y, cy + walk_x);
            run[4] = span(cx + walk_x, cx + walk_x, cy - walk_y);
            run[5] = span(cx + walk_y, cx + walk_y, cy - walk_x);
            run[6] = span(cx - walk_x, cx - walk_x, cy - walk_y);
            run[7] = span(cx - walk_y, cx - walk_y, cy - walk_x);
            n = crr_pkg::LINE_LAST + 1;
        end
        if (walk_err >= 2 * walk_x) begin
            walk_err -= 2 * walk_x + 1;
            walk_x++;
        end else if (walk_err < 2 * (int'(rad) - walk_y)) begin
            walk_err += 2 * walk_y - 1;
            walk_y--;
        end else begin
            walk_err += 2 * (walk_y - walk_x - 1);
            walk_y--;
            walk_x++;
        end
        finished = (walk_y < walk_x);
        if (finished) begin
            drawing = 1'b0;
        end
        for (int k = 0; k < n; k++) begin
            run[k].done = finished;
            run[k].last = (k == n - 1);
            spans_due.push_back(run[k]);
        end
    endtask

    task automatic check_span();
        span_t                        want;
        logic [crr_pkg::OUT_BITS-1:0] xs;
        logic [crr_pkg::OUT_BITS-1:0] xe;
        logic [crr_pkg::OUT_BITS-1:0] rw;
        xs = m_tdata[crr_pkg::OUT_BITS-1:0];
        xe = m_tdata[2*crr_pkg::OUT_BITS-1:crr_pkg::OUT_BITS];
        rw = m_tdata[3*crr_pkg::OUT_BITS-1:2*crr_pkg::OUT_BITS];
        if (spans_due.size() == 0) begin
            report($sformatf("result item (%0h,%0h,%0h) with nothing due", xs, xe, rw));
            return;
        end
        want = spans_due.pop_front();
        if (xs !== want.x_start) begin
            report($sformatf("x_start %0h, due %0h", xs, want.x_start));
        end
        if (xe !== want.x_end) begin
            report($sformatf("x_end %0h, due %0h", xe, want.x_end));
        end
        if (rw !== want.row) begin
            report($sformatf("row %0h, due %0h", rw, want.row));
        end
        if (m_tlast !== want.last) begin
            report($sformatf("last %b, due %b", m_tlast, want.last));
        end
        if (m_tuser !== want.done) begin
            report($sformatf("done %b, due %b", m_tuser, want.done));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ctr_col  = '0;
            ctr_row  = '0;
            rad      = '0;
            walk_x   = 0;
            walk_y   = 0;
            walk_err = 0;
            drawing  = 1'b0;
            fill     = 1'b0;
            spans_due.delete();
        end else begin
            if (cfg_wr_en) begin
                fill = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                rasterize(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                check_span();
            end
        end
        outstanding = spans_due.size();
    end

endmodule

FILE: test/circle_rasterizer_test.sv
// ----------------------------------------------------------------------------
// Circle rasterizer testbench
// Drives start and step commands, with a directed opening on the extremes and
// then random circles, mostly small ones stepped at random, across outline
// and fill settings. Both channels idle at random; one phase holds the result
// channel off for a long stretch. The checker does all the comparing.
// ----------------------------------------------------------------------------

module circle_rasterizer_test;

    localparam int LIMIT         = 500000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS   = 70;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [crr_pkg::S_TDATA_BITS-1:0] s_tdata;
    logic                             s_tuser;
    logic                             cfg_wr_en;
    logic                             cfg_wr_data;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [crr_pkg::M_TDATA_BITS-1:0] m_tdata;
    logic                             m_tlast;
    logic                             m_tuser;
    int                               mismatches;
    int                               outstanding;
    int                               cycle_cnt;
    int                               sent;
    bit                               hold_req;
    bit                               no_idle;

    circle_rasterizer u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    circle_rasterizer_check u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int gap_len();
        int p;
        if (no_idle) begin
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 55) begin
            return 0;
        end
        if (p < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [crr_pkg::COORD_BITS-1:0] rand_coord();
        return crr_pkg::COORD_BITS'($urandom_range(0, 4095));
    endfunction

    function automatic logic [crr_pkg::RADIUS_BITS-1:0] rand_radius(int hi);
        return crr_pkg::RADIUS_BITS'($urandom_range(0, hi));
    endfunction

    function automatic logic [crr_pkg::COORD_BITS-1:0] pick_coord();
        int p;
        p = $urandom_range(0, 3);
        if (p == 0) begin
            return crr_pkg::COORD_BITS'($urandom_range(0, 15));
        end
        if (p == 1) begin
            return crr_pkg::COORD_BITS'($urandom_range(4080, 4095));
        end
        return rand_coord();
    endfunction

    task automatic put_cmd(logic cmd, logic [crr_pkg::COORD_BITS-1:0] cx,
                           logic [crr_pkg::COORD_BITS-1:0] cy,
                           logic [crr_pkg::RADIUS_BITS-1:0] r);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(crr_pkg::S_TDATA_BITS - crr_pkg::S_FIELD_BITS){1'b0}}, r, cy, cx};
        do @(posedge aclk); while (!s_tready);
        sent++;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic put_step();
        put_cmd(crr_pkg::CMD_STEP, rand_coord(), rand_coord(), rand_radius(1023));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_fill(logic v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly small circles stepped at random, not always to the end, a few large
    // ones cut short by the next start, and some stray commands as noise.
    task automatic random_circle();
        int                              p;
        int                              steps;
        logic [crr_pkg::RADIUS_BITS-1:0] r;
        p = $urandom_range(0, 99);
        if (p < 15) begin
            put_cmd(($urandom_range(0, 1) == 1) ? crr_pkg::CMD_STEP : crr_pkg::CMD_START,
                    rand_coord(), rand_coord(), rand_radius(1023));
            return;
        end
        if (p < 27) begin
            r = rand_radius(1023);
            steps = $urandom_range(1, 4);
        end else begin
            r = rand_radius(15);
            steps = $urandom_range(1, int'(r) + 3);
        end
        put_cmd(crr_pkg::CMD_START, pick_coord(), pick_coord(), r);
        repeat (steps) put_step();
    endtask

    task automatic run_phase(int items);
        int target;
        target = sent + items;
        while (sent < target) random_circle();
    endtask

    initial begin
        m_tready <= 1'b0;
        forever begin
            int stall;
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                stall = 0;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = gap_len();
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        sent     = 0;
        hold_req = 1'b0;
        no_idle  = 1'b0;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tuser     <= crr_pkg::CMD_START;
        s_tdata     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Outline mode straight out of reset.
        put_step();
        put_cmd(crr_pkg::CMD_START, 12'd0, 12'd0, 10'd0);
        put_step();
        put_step();
        put_cmd(crr_pkg::CMD_START, 12'd4095, 12'd4095, 10'd1023);
        repeat (3) put_step();
        put_cmd(crr_pkg::CMD_START, 12'd0, 12'd0, 10'd1023);
        repeat (2) put_step();
        put_cmd(crr_pkg::CMD_START, 12'd2048, 12'd2048, 10'd1);
        repeat (3) put_step();

        set_fill(1'b1);
        put_cmd(crr_pkg::CMD_START, 12'd4095, 12'd0, 10'd1023);
        repeat (2) put_step();
        put_cmd(crr_pkg::CMD_START, 12'd0, 12'd4095, 10'd0);
        put_step();
        put_step();

        set_fill(1'b0);
        run_phase(PHASE_ITEMS);

        set_fill(1'b1);
        hold_req = 1'b1;
        run_phase(PHASE_ITEMS);

        set_fill(1'b1);
        no_idle = 1'b1;
        run_phase(PHASE_ITEMS);
        no_idle = 1'b0;

        set_fill(1'b0);
        run_phase(PHASE_ITEMS);

        settle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
